FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk, quiet during rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every edge out of reset
`define FMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define FMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FMS_ASSERT(lbl, prop, msg)
`define FMS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/fms_pkg.sv
// ----------------------------------------------------------------------------
// fms_pkg
// Types, score constants and saturating helpers for the fuzzy match scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package fms_pkg;

  localparam int SCORE_W = 24;
  localparam int DELTA_W = 12;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [DELTA_W-1:0] delta_t;

  localparam score_t NEG_INF   = 24'h80_0000;
  localparam score_t SCORE_TOP = 24'h7F_FFFF;
  localparam score_t SCORE_ZERO = 24'h00_0000;

  localparam logic signed [SCORE_W:0] SUM_TOP = 25'sd8388607;
  localparam logic signed [SCORE_W:0] SUM_LOW = -25'sd8388607;

  localparam delta_t GAP_EDGE      = -12'sd5;
  localparam delta_t GAP_INNER     = -12'sd10;
  localparam delta_t BONUS_CONSEC  = 12'sd1000;
  localparam delta_t BONUS_SLASH   = 12'sd900;
  localparam delta_t BONUS_WORD    = 12'sd800;
  localparam delta_t BONUS_CAPITAL = 12'sd700;
  localparam delta_t BONUS_DOT     = 12'sd600;
  localparam delta_t BONUS_NONE    = 12'sd0;

  // item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_CAND   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_SCORED   = 3'd0;
  localparam logic [2:0] ST_NO_MATCH = 3'd1;
  localparam logic [2:0] ST_EXACT    = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_value;
    logic       last_item;
  } in_item_t;

  typedef struct packed {
    score_t     score;
    logic [2:0] status;
  } out_item_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic       nclr;       // drop the needle
    logic       shift;      // append: needle shifts one cell left
    logic       cclr;       // candidate restart: scores to -inf
    logic       step;       // column update
    logic       pos0;       // first candidate character
    logic [7:0] raw;
    logic [7:0] low_ch;
    delta_t     bonus;
    score_t     lead_bonus; // leading gap plus bonus for the first needle char
  } cell_ctrl_t;

  // -inf stays -inf, finite sums clamp to the score range
  function automatic score_t add_sat(score_t a, delta_t b);
    logic signed [SCORE_W:0] s;
    s = $signed({a[SCORE_W-1], a}) + $signed({{(SCORE_W+1-DELTA_W){b[DELTA_W-1]}}, b});
    if (a == NEG_INF) begin
      add_sat = NEG_INF;
    end else if (s > SUM_TOP) begin
      add_sat = SCORE_TOP;
    end else if (s < SUM_LOW) begin
      add_sat = NEG_INF + score_t'(1);
    end else begin
      add_sat = s[SCORE_W-1:0];
    end
  endfunction

  function automatic score_t max_score(score_t a, score_t b);
    max_score = (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fms_cell.sv
// ----------------------------------------------------------------------------
// fms_cell
// One needle position: its byte, its score pair and the equality token.
// ----------------------------------------------------------------------------
`default_nettype none

module fms_cell import fms_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  cell_ctrl_t  ctrl,
  input  wire         is_tail,
  // from the left neighbor (previous needle position)
  input  wire         vld_l,
  input  wire         tok_l,
  input  score_t      best_l,
  input  score_t      end_l,
  // from the right neighbor, for the append shift
  input  wire  [7:0]  chr_in,
  input  wire         vld_in,
  output logic        vld_o,
  output logic        first_o,
  output logic        tok_o,
  output logic [7:0]  chr_o,
  output score_t      best_o,
  output score_t      end_o,
  output score_t      best_upd_o
);

  logic       vld_r, vld_nxt;
  logic       tok_r, tok_nxt;
  logic [7:0] chr_r, chr_nxt;
  score_t     best_r, best_nxt;
  score_t     end_r, end_nxt;

  logic       first;
  logic       tok_now;
  logic       hit;
  score_t     d;
  score_t     carried;
  score_t     upd;

  always_comb begin
    first   = vld_r & ~vld_l;
    tok_now = ctrl.pos0 ? first : tok_r;
    hit     = vld_r & (chr_r == ctrl.low_ch);

    if (!hit) begin
      d = NEG_INF;
    end else if (first) begin
      d = ctrl.lead_bonus;
    end else if (ctrl.pos0) begin
      d = NEG_INF;
    end else begin
      d = max_score(add_sat(best_l, ctrl.bonus), add_sat(end_l, BONUS_CONSEC));
    end

    carried = ctrl.pos0 ? NEG_INF : add_sat(best_r, is_tail ? GAP_EDGE : GAP_INNER);
    upd     = max_score(d, carried);
  end

  always_comb begin
    vld_nxt  = vld_r;
    chr_nxt  = chr_r;
    tok_nxt  = tok_r;
    best_nxt = best_r;
    end_nxt  = end_r;
    if (ctrl.nclr) begin
      vld_nxt = 1'b0;
    end else if (ctrl.shift) begin
      vld_nxt = vld_in;
      chr_nxt = chr_in;
    end
    if (ctrl.step) begin
      tok_nxt = tok_l;
    end
    if (ctrl.cclr) begin
      best_nxt = NEG_INF;
      end_nxt  = NEG_INF;
    end else if (ctrl.step) begin
      best_nxt = upd;
      end_nxt  = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      tok_r  <= 1'b0;
      best_r <= NEG_INF;
      end_r  <= NEG_INF;
    end else begin
      vld_r  <= vld_nxt;
      tok_r  <= tok_nxt;
      best_r <= best_nxt;
      end_r  <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chr_r <= chr_nxt;
  end

  assign vld_o      = vld_r;
  assign first_o    = first;
  assign tok_o      = tok_now & (chr_r == ctrl.raw);
  assign chr_o      = chr_r;
  assign best_o     = best_r;
  assign end_o      = end_r;
  assign best_upd_o = upd;

endmodule

`default_nettype wire

FILE: rtl/fms_chain.sv
// ----------------------------------------------------------------------------
// fms_chain
// Row of needle cells; the needle is kept right-aligned so the tail cell
// always holds the last needle byte and the final score.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fms_chain import fms_pkg::*; #(
  parameter int N = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  cell_ctrl_t  ctrl,
  output score_t      tail_best,
  output logic        tail_exit
);

  logic [N-1:0] vld;
  logic [N-1:0] first;
  logic [N-1:0] tok;
  logic [7:0]   chr  [N];
  score_t       best [N];
  score_t       endv [N];
  score_t       upd  [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic       vld_l, tok_l, vld_in;
    score_t     best_l, end_l;
    logic [7:0] chr_in;

    if (i == 0) begin : g_head
      assign vld_l  = 1'b0;
      assign tok_l  = 1'b0;
      assign best_l = NEG_INF;
      assign end_l  = NEG_INF;
    end else begin : g_body
      assign vld_l  = vld[i-1];
      assign tok_l  = tok[i-1];
      assign best_l = best[i-1];
      assign end_l  = endv[i-1];
    end

    // new needle bytes enter at the tail
    if (i == N-1) begin : g_tail
      assign chr_in = ctrl.raw;
      assign vld_in = 1'b1;
    end else begin : g_inner
      assign chr_in = chr[i+1];
      assign vld_in = vld[i+1];
    end

    fms_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .is_tail    (i == N-1),
      .vld_l      (vld_l),
      .tok_l      (tok_l),
      .best_l     (best_l),
      .end_l      (end_l),
      .chr_in     (chr_in),
      .vld_in     (vld_in),
      .vld_o      (vld[i]),
      .first_o    (first[i]),
      .tok_o      (tok[i]),
      .chr_o      (chr[i]),
      .best_o     (best[i]),
      .end_o      (endv[i]),
      .best_upd_o (upd[i])
    );
  end

  assign tail_best = upd[N-1];
  // token leaving the tail: every needle byte matched in order
  assign tail_exit = tok[N-1];

  `FMS_ASSERT(a_first_unique, $onehot0(first), "more than one head of needle")
  `FMS_ASSERT(a_tok_unique, $onehot0(tok), "equality token duplicated")
  `FMS_ASSERT(a_right_aligned, !(|vld) || vld[N-1], "needle not right-aligned")

endmodule

`default_nettype wire

FILE: rtl/fuzzy_match_score.sv
// ----------------------------------------------------------------------------
// fuzzy_match_score
// Fuzzy subsequence scorer: needle held in a row of cells, one DP column
// per candidate byte.
// ----------------------------------------------------------------------------
//   port group  dir  handshake            payload
//   in_*        in   in_valid / in_stall   in_item_t  (kind, char_value, last_item)
//   out_*       out  out_valid / out_stall out_item_t (score, status)
//
// One item per cycle while in_stall is low: all MAX_LEN cells update
// their column entry in parallel from the left neighbor's previous values.
// The result is registered and shows on out_* the cycle after the final byte.
// in_stall rises only while a result waits and out_stall is high.
// After reset the block takes items at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fuzzy_match_score import fms_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  wire        out_stall,
  output out_item_t  out_data
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int LW = $clog2(5 * MAX_LEN + 1) + 1;
  localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LEN);

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 novf_r, novf_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic                 covf_r, covf_nxt;
  logic [7:0]           prev_r, prev_nxt;
  logic signed [LW-1:0] lead_r, lead_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic       acc;
  logic       is_clear, is_append, is_cand;
  logic       pos_room;
  logic       res;
  logic       covf_now;
  logic [7:0] raw;
  logic [7:0] low_ch;
  delta_t     bonus;
  cell_ctrl_t ctrl;
  score_t     tail_best;
  logic       tail_exit;

  assign in_stall  = out_valid_r & out_stall;
  assign acc       = in_valid & ~in_stall;
  assign raw       = in_data.char_value;
  assign is_clear  = acc & (in_data.kind == KIND_CLEAR);
  assign is_append = acc & (in_data.kind == KIND_APPEND);
  assign is_cand   = acc & (in_data.kind == KIND_CAND);
  assign pos_room  = pos_r < LEN_MAX;
  assign res       = is_cand & in_data.last_item;
  assign covf_now  = covf_r | ~pos_room;

  always_comb begin
    low_ch = (raw inside {[CH_UP_A:CH_UP_Z]}) ? raw + CASE_OFS : raw;
    if (prev_r == CH_SLASH) begin
      bonus = BONUS_SLASH;
    end else if (raw inside {CH_DASH, CH_UNDER, CH_SPACE}) begin
      bonus = BONUS_WORD;
    end else if (raw == CH_DOT) begin
      bonus = BONUS_DOT;
    end else if ((raw inside {[CH_UP_A:CH_UP_Z]}) && (prev_r inside {[CH_LO_A:CH_LO_Z]})) begin
      bonus = BONUS_CAPITAL;
    end else begin
      bonus = BONUS_NONE;
    end
  end

  always_comb begin
    ctrl.nclr       = is_clear;
    ctrl.shift      = is_append & (cnt_r < LEN_MAX);
    ctrl.cclr       = is_clear | is_append | res;
    ctrl.step       = is_cand & pos_room;
    ctrl.pos0       = (pos_r == '0);
    ctrl.raw        = raw;
    ctrl.low_ch     = low_ch;
    ctrl.bonus      = bonus;
    ctrl.lead_bonus = add_sat(SCORE_W'(lead_r), bonus);
  end

  fms_chain #(.N(MAX_LEN)) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .tail_best (tail_best),
    .tail_exit (tail_exit)
  );

  always_comb begin
    cnt_nxt  = cnt_r;
    novf_nxt = novf_r;
    pos_nxt  = pos_r;
    covf_nxt = covf_r;
    prev_nxt = prev_r;
    lead_nxt = lead_r;

    if (is_clear) begin
      cnt_nxt  = '0;
      novf_nxt = 1'b0;
    end else if (is_append) begin
      if (cnt_r < LEN_MAX) begin
        cnt_nxt = cnt_r + CW'(1);
      end else begin
        novf_nxt = 1'b1;
      end
    end

    if (is_cand) begin
      if (pos_room) begin
        pos_nxt  = pos_r + CW'(1);
        prev_nxt = raw;
        lead_nxt = lead_r - LW'(5);
      end else begin
        covf_nxt = 1'b1;
      end
    end

    // any needle change or a finished candidate restarts the candidate
    if (ctrl.cclr) begin
      pos_nxt  = '0;
      covf_nxt = 1'b0;
      prev_nxt = CH_SLASH;
      lead_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (res) begin
      out_valid_nxt = 1'b1;
      if ((cnt_r == '0) && !novf_r) begin
        out_data_nxt.score  = SCORE_ZERO;
        out_data_nxt.status = ST_EMPTY;
      end else if (novf_r || covf_now) begin
        out_data_nxt.score  = NEG_INF;
        out_data_nxt.status = ST_TOO_LONG;
      end else if (tail_exit) begin
        out_data_nxt.score  = SCORE_TOP;
        out_data_nxt.status = ST_EXACT;
      end else begin
        out_data_nxt.score  = tail_best;
        out_data_nxt.status = (tail_best == NEG_INF) ? ST_NO_MATCH : ST_SCORED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      novf_r      <= 1'b0;
      pos_r       <= '0;
      covf_r      <= 1'b0;
      prev_r      <= CH_SLASH;
      lead_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      novf_r      <= novf_nxt;
      pos_r       <= pos_nxt;
      covf_r      <= covf_nxt;
      prev_r      <= prev_nxt;
      lead_r      <= lead_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FMS_ASSERT(a_cnt_bound, cnt_r <= LEN_MAX, "needle count past capacity")
  `FMS_ASSERT(a_ovf_full, !novf_r || (cnt_r == LEN_MAX), "needle overflow below capacity")
  `FMS_ASSERT_NEXT(a_res_out, res, out_valid, "final byte transfer gave no result")
  `FMS_ASSERT_NEXT(a_cand_restart, ctrl.cclr, (pos_r == '0) && !covf_r, "candidate not restarted")

endmodule

`default_nettype wire
